[design/qwmb_pkg.sv]
// Shared types, constants and helpers for the move-to-tail key queue.
package qwmb_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Command codes; code 3 is unused and treated as a no-op
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_ADMIT = 2'd1,
      CMD_MOVE  = 2'd2
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ADMIT,
      S_SEARCH,
      S_SHIFT,
      S_TAIL
   } state_type;

   // Read offset select: head entry or entry after the scan index
   typedef enum logic {
      RD_HEAD,
      RD_NEXT
   } rd_sel_type;

   // Write select: append at tail, shift down one, or re-append moved key
   typedef enum logic [1:0] {
      WR_PUSH,
      WR_SHIFT,
      WR_TAIL
   } wr_sel_type;

   // Result key select
   typedef enum logic [1:0] {
      KEY_ZERO,
      KEY_READ,
      KEY_HELD
   } key_sel_type;

   // Request and result payloads
   typedef struct packed {
      logic [1:0]           command;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [KEY_WIDTH-1:0] out_key;
      logic [COUNT_W-1:0]   queue_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        latch;
      logic        idx_clear;
      logic        idx_inc;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      logic        head_inc;
      logic        count_inc;
      logic        count_dec;
      logic        rsp_en;
      status_type  rsp_status;
      key_sel_type key_sel;
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] command;
      logic       full;
      logic       empty;
      logic       match;
      logic       last;
   } stat_type;

   // Circular address of the entry at offset off from base
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [COUNT_W-1:0] off);
      logic [COUNT_W:0] sum;
      sum = (COUNT_W+1)'(base) + (COUNT_W+1)'(off);
      if (sum >= (COUNT_W+1)'(QUEUE_DEPTH)) begin
         sum = sum - (COUNT_W+1)'(QUEUE_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

[design/qwmb_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module qwmb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/qwmb_ctrl.sv]
// Controller state machine sequencing push, admit and move over the datapath.
module qwmb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  qwmb_pkg::stat_type stat,
   output qwmb_pkg::ctrl_type ctrl
);

   qwmb_pkg::state_type state_ff;
   qwmb_pkg::state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qwmb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         qwmb_pkg::S_IDLE: begin
            if (start) begin
               state_in = qwmb_pkg::S_DECODE;
            end
         end
         qwmb_pkg::S_DECODE: begin
            case (stat.command)
               qwmb_pkg::CMD_ADMIT: begin
                  state_in = stat.empty ? qwmb_pkg::S_IDLE : qwmb_pkg::S_ADMIT;
               end
               qwmb_pkg::CMD_MOVE: begin
                  state_in = stat.empty ? qwmb_pkg::S_IDLE : qwmb_pkg::S_SEARCH;
               end
               default: begin
                  state_in = qwmb_pkg::S_IDLE;
               end
            endcase
         end
         qwmb_pkg::S_ADMIT: begin
            state_in = qwmb_pkg::S_IDLE;
         end
         qwmb_pkg::S_SEARCH: begin
            if (stat.match) begin
               state_in = stat.last ? qwmb_pkg::S_IDLE : qwmb_pkg::S_SHIFT;
            end else if (stat.last) begin
               state_in = qwmb_pkg::S_IDLE;
            end
         end
         qwmb_pkg::S_SHIFT: begin
            if (stat.last) begin
               state_in = qwmb_pkg::S_TAIL;
            end
         end
         qwmb_pkg::S_TAIL: begin
            state_in = qwmb_pkg::S_IDLE;
         end
         default: begin
            state_in = qwmb_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctrl            = '0;
      ctrl.rd_sel     = qwmb_pkg::RD_HEAD;
      ctrl.wr_sel     = qwmb_pkg::WR_PUSH;
      ctrl.rsp_status = qwmb_pkg::ST_OK;
      ctrl.key_sel    = qwmb_pkg::KEY_ZERO;
      busy            = 1'b1;
      unique case (state_ff)
         qwmb_pkg::S_IDLE: begin
            busy       = 1'b0;
            ctrl.latch = start;
         end
         qwmb_pkg::S_DECODE: begin
            case (stat.command)
               qwmb_pkg::CMD_PUSH: begin
                  ctrl.rsp_en = 1'b1;
                  if (stat.full) begin
                     ctrl.rsp_status = qwmb_pkg::ST_FULL;
                  end else begin
                     ctrl.wr_en     = 1'b1;
                     ctrl.count_inc = 1'b1;
                  end
               end
               qwmb_pkg::CMD_ADMIT: begin
                  if (stat.empty) begin
                     ctrl.rsp_en     = 1'b1;
                     ctrl.rsp_status = qwmb_pkg::ST_EMPTY;
                  end
               end
               qwmb_pkg::CMD_MOVE: begin
                  ctrl.idx_clear = 1'b1;
                  if (stat.empty) begin
                     ctrl.rsp_en     = 1'b1;
                     ctrl.rsp_status = qwmb_pkg::ST_NOT_FOUND;
                  end
               end
               default: begin
                  ctrl.rsp_en = 1'b1;
               end
            endcase
         end
         qwmb_pkg::S_ADMIT: begin
            ctrl.rsp_en    = 1'b1;
            ctrl.key_sel   = qwmb_pkg::KEY_READ;
            ctrl.head_inc  = 1'b1;
            ctrl.count_dec = 1'b1;
         end
         qwmb_pkg::S_SEARCH: begin
            ctrl.rd_sel  = qwmb_pkg::RD_NEXT;
            ctrl.idx_inc = 1'b1;
            if (stat.match && stat.last) begin
               ctrl.rsp_en  = 1'b1;
               ctrl.key_sel = qwmb_pkg::KEY_HELD;
            end else if (!stat.match && stat.last) begin
               ctrl.rsp_en     = 1'b1;
               ctrl.rsp_status = qwmb_pkg::ST_NOT_FOUND;
            end
         end
         qwmb_pkg::S_SHIFT: begin
            ctrl.rd_sel  = qwmb_pkg::RD_NEXT;
            ctrl.idx_inc = 1'b1;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_sel  = qwmb_pkg::WR_SHIFT;
         end
         qwmb_pkg::S_TAIL: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_sel  = qwmb_pkg::WR_TAIL;
            ctrl.rsp_en  = 1'b1;
            ctrl.key_sel = qwmb_pkg::KEY_HELD;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[design/qwmb_dp.sv]
// Datapath: circular key store, head/count/index registers and result register.
module qwmb_dp (
   input  logic               clock,
   input  logic               reset,
   input  qwmb_pkg::req_type  req_data,
   input  qwmb_pkg::ctrl_type ctrl,
   output qwmb_pkg::stat_type stat,
   output logic               rsp_strobe,
   output qwmb_pkg::rsp_type  rsp_data
);

   logic [1:0]                      cmd_ff;
   logic [qwmb_pkg::KEY_WIDTH-1:0]  key_ff;
   logic [qwmb_pkg::ADDR_W-1:0]     head_ff;
   logic [qwmb_pkg::COUNT_W-1:0]    count_ff;
   logic [qwmb_pkg::COUNT_W-1:0]    idx_ff;
   logic [qwmb_pkg::COUNT_W-1:0]    idx_in;
   logic                            rsp_strobe_ff;
   qwmb_pkg::status_type            rsp_status_ff;
   logic [qwmb_pkg::KEY_WIDTH-1:0]  rsp_key_ff;
   logic [qwmb_pkg::KEY_WIDTH-1:0]  rsp_key_in;

   logic [qwmb_pkg::COUNT_W-1:0]    rd_off;
   logic [qwmb_pkg::COUNT_W-1:0]    wr_off;
   logic [qwmb_pkg::ADDR_W-1:0]     rd_addr;
   logic [qwmb_pkg::ADDR_W-1:0]     wr_addr;
   logic [qwmb_pkg::KEY_WIDTH-1:0]  wr_data;
   logic [qwmb_pkg::KEY_WIDTH-1:0]  rd_data;

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         cmd_ff <= req_data.command;
         key_ff <= req_data.key;
      end
   end

   // Advance head, count and scan index
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (ctrl.head_inc) begin
            head_ff <= qwmb_pkg::wrap_addr(head_ff, qwmb_pkg::COUNT_W'(1));
         end
         if (ctrl.count_inc) begin
            count_ff <= count_ff + qwmb_pkg::COUNT_W'(1);
         end else if (ctrl.count_dec) begin
            count_ff <= count_ff - qwmb_pkg::COUNT_W'(1);
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctrl.idx_clear) begin
         idx_in = '0;
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + qwmb_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Select read and write offsets from the head
   assign rd_off = (ctrl.rd_sel == qwmb_pkg::RD_NEXT) ? idx_ff + qwmb_pkg::COUNT_W'(1) : '0;

   always_comb begin
      wr_off  = count_ff;
      wr_data = key_ff;
      case (ctrl.wr_sel)
         qwmb_pkg::WR_SHIFT: begin
            wr_off  = idx_ff - qwmb_pkg::COUNT_W'(1);
            wr_data = rd_data;
         end
         qwmb_pkg::WR_TAIL: begin
            wr_off = count_ff - qwmb_pkg::COUNT_W'(1);
         end
         default: begin
            wr_off = count_ff;
         end
      endcase
   end

   assign rd_addr = qwmb_pkg::wrap_addr(head_ff, rd_off);
   assign wr_addr = qwmb_pkg::wrap_addr(head_ff, wr_off);

   qwmb_ram #(
      .WIDTH (qwmb_pkg::KEY_WIDTH),
      .DEPTH (qwmb_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status back to the controller
   assign stat.command = cmd_ff;
   assign stat.full    = (count_ff == qwmb_pkg::COUNT_W'(qwmb_pkg::QUEUE_DEPTH));
   assign stat.empty   = (count_ff == '0);
   assign stat.match   = (rd_data == key_ff);
   assign stat.last    = (idx_ff == count_ff - qwmb_pkg::COUNT_W'(1));

   // Result register and strobe
   always_comb begin
      case (ctrl.key_sel)
         qwmb_pkg::KEY_READ: rsp_key_in = rd_data;
         qwmb_pkg::KEY_HELD: rsp_key_in = key_ff;
         default:            rsp_key_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rsp_en) begin
         rsp_status_ff <= ctrl.rsp_status;
         rsp_key_ff    <= rsp_key_in;
      end
   end

   // Count is final by the time the result is shown
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_data.status      = rsp_status_ff;
   assign rsp_data.out_key     = rsp_key_ff;
   assign rsp_data.queue_count = count_ff;

endmodule

[design/queue_with_move_to_back.sv]
// Top level of the ordered key queue with move-to-tail.
//
// Request channel: drive req_data (command and key) with start high; the
// transfer happens at a clock edge where start is high and busy is low.
// Commands: push appends the key at the tail, admit removes the head and
// returns its key, move finds the first entry equal to the key (from the
// head), pulls it out and re-appends it at the tail.
// Result channel: exactly one result per request, shown on rsp_data for one
// cycle with rsp_strobe high. The receiver cannot stall; it must take it.
// Push, no-op and refused commands (full push, empty admit, move on an empty
// queue) are answered from the decode state; admit first reads the head. A
// move searches from the head to the match, closes the gap entry by entry
// and re-appends the key; when the key is missing or at the tail it ends
// with the search. The search reads one entry a cycle, and closing the gap
// moves one entry a cycle; both are set by the single read port of the key RAM.
// busy is high from the transfer until the result cycle; a new request can
// be taken in the same cycle that the result is shown.
// Reset (synchronous, active high) empties the queue; the key RAM is not
// cleared since read data from entries that are not held is never used.
module queue_with_move_to_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qwmb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output qwmb_pkg::rsp_type rsp_data
);

   qwmb_pkg::ctrl_type ctrl;
   qwmb_pkg::stat_type stat;

   qwmb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   qwmb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .ctrl       (ctrl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/tb.sv]
// Testbench for the move-to-tail key queue: directed and random commands checked against a queue model.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qwmb_pkg::*;

   // Command code 3 is unused by the block and acts as a no-op
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam int RANDOM_ITEMS = 1650;
   localparam int PHASE_ITEMS  = 50;
   localparam int POOL_SIZE    = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

   typedef struct {
      req_type     req;
      int unsigned gap;
   } item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   item_type             pending[$];
   rsp_type              due_results[$];
   logic [KEY_WIDTH-1:0] held_keys[$];
   logic                 req_taken = 1'b0;
   int unsigned          gap_left = 0;
   int unsigned          fault_count = 0;
   int unsigned          cycle_count = 0;

   queue_with_move_to_back dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one command to the held keys and return the result it gives
   function automatic rsp_type apply_command(req_type req);
      rsp_type res;
      int      hit;
      res.status  = ST_OK;
      res.out_key = '0;
      hit = -1;
      case (req.command)
         CMD_PUSH: begin
            if (held_keys.size() >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_keys.push_back(req.key);
            end
         end
         CMD_ADMIT: begin
            if (held_keys.size() == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.out_key = held_keys.pop_front();
            end
         end
         CMD_MOVE: begin
            // first match from the head wins; a tail or lone entry stays put
            foreach (held_keys[i]) begin
               if (hit < 0 && held_keys[i] == req.key) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               held_keys.delete(hit);
               held_keys.push_back(req.key);
               res.out_key = req.key;
            end
         end
         default: begin
            // no-op code: queue unchanged
         end
      endcase
      res.queue_count = COUNT_W'(held_keys.size());
      return res;
   endfunction

   task automatic note_fault(string what, rsp_type want, rsp_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t %s: want status %0d key %h count %0d, got status %0d key %h count %0d",
                  $time, what, want.status, want.out_key, want.queue_count,
                  got.status, got.out_key, got.queue_count);
      end
   endtask

   task automatic add_item(logic [1:0] command, logic [KEY_WIDTH-1:0] key, int unsigned gap);
      item_type it;
      it.req.command = command;
      it.req.key     = key;
      it.gap         = gap;
      pending.push_back(it);
   endtask

   // Driver: present the next item at the falling edge, hold it until the transfer
   always @(negedge clock) begin
      item_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending.size() != 0) begin
            nxt = pending.pop_front();
            req_data <= nxt.req;
            gap_left <= nxt.gap;
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predict each transfer and check each strobed result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               note_fault("unexpected result", '0, rsp_data);
            end else begin
               want = due_results.pop_front();
               if (rsp_data.status !== want.status || rsp_data.out_key !== want.out_key ||
                   rsp_data.queue_count !== want.queue_count) begin
                  note_fault("result mismatch", want, rsp_data);
               end
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) begin
            due_results.push_back(apply_command(req_data));
         end
      end
   end

   // Timeout guard
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      logic [KEY_WIDTH-1:0] key_pool[POOL_SIZE];
      logic [KEY_WIDTH-1:0] key;
      logic [1:0]           command;
      int unsigned          phase_kind;
      int unsigned          roll;
      int unsigned          gap;
      bit                   no_gaps;

      // Directed: empty queue, no-op, lone entry, duplicates, head and tail moves
      add_item(CMD_ADMIT, '1, 0);
      add_item(CMD_MOVE, '0, 1);
      add_item(CMD_NOP, '1, 0);
      add_item(CMD_PUSH, '0, 7);
      add_item(CMD_MOVE, '0, 0);
      add_item(CMD_PUSH, '1, 2);
      add_item(CMD_PUSH, '0, 0);
      add_item(CMD_MOVE, '0, 0);
      add_item(CMD_MOVE, '1, 3);
      add_item(CMD_MOVE, 32'h5a5a_5a5a, 0);
      add_item(CMD_MOVE, '0, 0);
      add_item(CMD_NOP, '0, 5);
      add_item(CMD_ADMIT, '0, 0);
      add_item(CMD_ADMIT, '1, 0);
      add_item(CMD_ADMIT, '0, 1);
      add_item(CMD_ADMIT, '0, 0);

      // Random phases: fill, drain, move-heavy and mixed, keys mostly from a small pool
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            phase_kind = $urandom_range(0, 3);
            no_gaps    = ($urandom_range(0, 2) == 0);
            foreach (key_pool[j]) begin
               key_pool[j] = $urandom;
            end
            key_pool[0] = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end
         roll = $urandom_range(0, 99);
         case (phase_kind)
            0: command = (roll < 70) ? CMD_PUSH : (roll < 80) ? CMD_ADMIT : CMD_MOVE;
            1: command = (roll < 15) ? CMD_PUSH : (roll < 75) ? CMD_ADMIT : CMD_MOVE;
            2: command = (roll < 20) ? CMD_PUSH : (roll < 40) ? CMD_ADMIT : CMD_MOVE;
            default: command = (roll < 35) ? CMD_PUSH : (roll < 65) ? CMD_ADMIT : CMD_MOVE;
         endcase
         if ($urandom_range(0, 99) < 3) begin
            command = CMD_NOP;
         end
         key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : KEY_WIDTH'($urandom);
         gap = no_gaps ? 0 : $urandom_range(0, 7);
         add_item(command, key, gap);
      end

      // Hold reset, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every transfer, every result, then let the block settle
      while (pending.size() != 0 || start) begin
         @(posedge clock);
      end
      while (due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
